>>> src/krt_pkg.sv
// ----------------------------------------------------------------------------
// krt_pkg
// Shared constants and types for the keyed record table.
// ----------------------------------------------------------------------------
`default_nettype none

package krt_pkg;

    localparam int DEPTH    = 16;
    localparam int KEY_BITS = 64;

    localparam int KEY_W   = 64;
    localparam int PRICE_W = 31;
    localparam int TOTAL_W = 32;
    localparam int CMD_W   = 3;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W   = $clog2(DEPTH);

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_LOOKUP = 3'd3,
        CMD_FIND   = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [PRICE_W-1:0]  price;
        logic [TOTAL_W-1:0]  total;
    } rec_t;

    typedef struct packed {
        logic                found;
        logic                accepted;
        logic [TOTAL_W-1:0]  total;
        logic [PRICE_W-1:0]  price;
        logic [KEY_BITS-1:0] key;
    } rsp_t;

endpackage

`default_nettype wire

>>> src/keyed_record_table_unit.sv
// ----------------------------------------------------------------------------
// keyed_record_table_unit
// Unordered packed record table with insert, delete, key lookup and
// search by total, held in one synchronous record memory.
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir
//  cmd     | cmd_valid cmd_ready command key price total | in
//  rsp     | rsp_valid rsp_ready found accepted total_out | out
//          | price_out key_out entry_count is_empty is_full |
//
//  Clear, insert and unused codes go straight from idle to the result state.
//  Lookup, find and delete: one memory read per cycle walks the records, and
//  delete continues with one read and one write per cycle to close the gap.
//  A new beat is taken while the previous result waits on rsp_ready.
//  Reset empties the table at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_record_table_unit
    import krt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    output logic                     cmd_ready,
    input  wire logic [CMD_W-1:0]    command,
    input  wire logic [KEY_W-1:0]    key,
    input  wire logic [PRICE_W-1:0]  price,
    input  wire logic [TOTAL_W-1:0]  total,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output logic                     found,
    output logic                     accepted,
    output logic [TOTAL_W-1:0]       total_out,
    output logic [PRICE_W-1:0]       price_out,
    output logic [KEY_W-1:0]         key_out,
    output logic [COUNT_W-1:0]       entry_count,
    output logic                     is_empty,
    output logic                     is_full
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    rec_t mem [DEPTH];
    rec_t rd_data_reg;

    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    cmd_t                cmd_reg, cmd_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    rsp_t                res_reg, res_next;
    rsp_t                out_reg, out_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    rec_t                wr_data;

    logic [IDX_W-1:0]    idx_inc;
    logic [COUNT_W-1:0]  idx_ext;
    logic                more1;
    logic                more2;
    logic                hit;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign idx_inc = idx_reg + IDX_W'(1);
    assign idx_ext = COUNT_W'(idx_reg);
    assign more1   = (idx_ext + COUNT_W'(1)) < count_reg;
    assign more2   = (idx_ext + COUNT_W'(2)) < count_reg;
    assign hit     = (cmd_reg == CMD_FIND) ? (rd_data_reg.total == total_reg)
                                           : (rd_data_reg.key == key_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        total_next     = total_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_count_next = out_count_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rd_en          = 1'b0;
        rd_addr        = idx_inc;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = rd_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd_t'(command);
                    key_next   = key[KEY_BITS-1:0];
                    total_next = total;
                    res_next   = '0;
                    idx_next   = '0;
                    state_next = S_DONE;
                    unique case (cmd_t'(command))
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_INSERT:
                        begin
                            if (count_reg < COUNT_W'(DEPTH))
                            begin
                                wr_en             = 1'b1;
                                wr_addr           = count_reg[IDX_W-1:0];
                                wr_data.key       = key[KEY_BITS-1:0];
                                wr_data.price     = price;
                                wr_data.total     = total;
                                count_next        = count_reg + COUNT_W'(1);
                                res_next.accepted = 1'b1;
                            end
                        end
                        CMD_DELETE, CMD_LOOKUP, CMD_FIND:
                        begin
                            if (count_reg != '0)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    res_next.found = 1'b1;
                    state_next     = S_DONE;
                    if (cmd_reg == CMD_LOOKUP)
                    begin
                        res_next.total = rd_data_reg.total;
                    end
                    else if (cmd_reg == CMD_FIND)
                    begin
                        res_next.price = rd_data_reg.price;
                        res_next.key   = rd_data_reg.key;
                    end
                    else if (more1)
                    begin
                        rd_en      = 1'b1;
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        count_next = count_reg - COUNT_W'(1);
                    end
                end
                else if (more1)
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_inc;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT:
            begin
                // rd_data_reg holds record idx+1; move it down to idx
                wr_en    = 1'b1;
                idx_next = idx_inc;
                if (more2)
                begin
                    rd_en   = 1'b1;
                    rd_addr = idx_reg + IDX_W'(2);
                end
                else
                begin
                    count_next = count_reg - COUNT_W'(1);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    out_next       = res_reg;
                    out_count_next = count_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        cmd_reg       <= cmd_next;
        key_reg       <= key_next;
        total_reg     <= total_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
        out_count_reg <= out_count_next;
    end

    always_comb
    begin
        key_out                 = '0;
        key_out[KEY_BITS-1:0]   = out_reg.key;
    end

    assign cmd_ready   = (state_reg == S_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign found       = out_reg.found;
    assign accepted    = out_reg.accepted;
    assign total_out   = out_reg.total;
    assign price_out   = out_reg.price;
    assign entry_count = out_count_reg;
    assign is_empty    = (out_count_reg == '0);
    assign is_full     = (out_count_reg == COUNT_W'(DEPTH));

endmodule

`default_nettype wire

>>> src/krt_checker.sv
// ----------------------------------------------------------------------------
// krt_checker
// Port-level checks on the keyed record table result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module krt_checker
    import krt_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               rsp_valid,
    input wire logic               rsp_ready,
    input wire logic               found,
    input wire logic               accepted,
    input wire logic [TOTAL_W-1:0] total_out,
    input wire logic [PRICE_W-1:0] price_out,
    input wire logic [KEY_W-1:0]   key_out,
    input wire logic [COUNT_W-1:0] entry_count,
    input wire logic               is_empty,
    input wire logic               is_full
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(found) && $stable(accepted)
            && $stable(total_out) && $stable(key_out) && $stable(entry_count))
        else $error("result beat changed while stalled");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (is_empty == (entry_count == '0))
            && (is_full == (entry_count == COUNT_W'(DEPTH))))
        else $error("status flags disagree with entry count");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> entry_count <= COUNT_W'(DEPTH))
        else $error("entry count beyond table depth");

    a_insert_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && accepted |-> !is_empty && !found)
        else $error("accepted insert with empty table or match flag");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !found |-> total_out == '0 && price_out == '0 && key_out == '0)
        else $error("payload nonzero without a match");

endmodule

bind keyed_record_table_unit krt_checker u_krt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .found       (found),
    .accepted    (accepted),
    .total_out   (total_out),
    .price_out   (price_out),
    .key_out     (key_out),
    .entry_count (entry_count),
    .is_empty    (is_empty),
    .is_full     (is_full)
);

`default_nettype wire
